// ===== rtl/core/soa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types, sizes and codes of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int NUM_SLABS   = 16;
  localparam int MAX_OBJECTS = 64;
  localparam int SLAB_W      = $clog2(NUM_SLABS);
  localparam int LINK_W      = SLAB_W + 1;
  localparam int OBJ_W       = $clog2(MAX_OBJECTS);
  localparam int FC_W        = OBJ_W + 1;
  localparam int ADDR_W      = SLAB_W + OBJ_W;
  localparam int CNT_W       = 5;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLABS);

  // slab classes
  localparam logic [1:0] CLS_UNUSED  = 2'd0;
  localparam logic [1:0] CLS_EMPTY   = 2'd1;
  localparam logic [1:0] CLS_PARTIAL = 2'd2;
  localparam logic [1:0] CLS_FULL    = 2'd3;

  // request codes
  localparam logic [1:0] FN_ALLOC  = 2'd0;
  localparam logic [1:0] FN_FREE   = 2'd1;
  localparam logic [1:0] FN_SHRINK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // config register indexes
  localparam logic REG_OBJS  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic              st_we;
    logic [ADDR_W-1:0] st_addr;
    logic [OBJ_W-1:0]  st_wdata;
    logic              iu_we;
    logic [ADDR_W-1:0] iu_addr;
    logic              iu_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLAB_W-1:0] slab;
    logic [OBJ_W-1:0]  obj;
    logic [CNT_W-1:0]  released;
    logic [CNT_W-1:0]  n_empty;
    logic [CNT_W-1:0]  n_partial;
    logic [CNT_W-1:0]  n_full;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/soa_obj_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soa_obj_mem
// Per-object storage: free stack entries and in-use flags, one port each.
// ----------------------------------------------------------------------------
module soa_obj_mem
  import soa_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic [OBJ_W-1:0]      st_rdata,
  output logic                  iu_rdata
);

  logic [OBJ_W-1:0] st_mem [NUM_SLABS*MAX_OBJECTS];
  logic             iu_mem [NUM_SLABS*MAX_OBJECTS];

  // stack: write and registered read at one address
  always_ff @(posedge clk) begin
    if (req.st_we) begin
      st_mem[req.st_addr] <= req.st_wdata;
    end
    st_rdata <= st_mem[req.st_addr];
  end

  // in-use flags
  always_ff @(posedge clk) begin
    if (req.iu_we) begin
      iu_mem[req.iu_addr] <= req.iu_wdata;
    end
    iu_rdata <= iu_mem[req.iu_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/soa_slab_ctl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soa_slab_ctl
// Sequencer over the slab table and class lists; one list or memory step
// per cycle, with separate counters for the slab search and for carving.
// ----------------------------------------------------------------------------
module soa_slab_ctl
  import soa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        in_func,
  input  wire logic [SLAB_W-1:0] in_slab_index,
  input  wire logic [OBJ_W-1:0]  in_object_index,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_index,
  input  wire logic [6:0]        cfg_data,
  output logic                   busy,
  output logic                   done,
  output result_t                res,
  output mem_req_t               mreq,
  input  wire logic [OBJ_W-1:0]  st_rdata,
  input  wire logic              iu_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ASEL, S_SEARCH, S_CARVE, S_POP, S_ARD,
    S_FCHK, S_FRD, S_UNLINK, S_PUSH, S_SHRINK, S_DONE
  } state_t;

  state_t state_r;

  logic [6:0]        objs_r;
  logic [4:0]        limit_r;
  logic [1:0]        cls_r  [NUM_SLABS];
  logic [FC_W-1:0]   fc_r   [NUM_SLABS];
  logic [FC_W-1:0]   cap_r  [NUM_SLABS];
  logic [LINK_W-1:0] nx_r   [NUM_SLABS];
  logic [LINK_W-1:0] pv_r   [NUM_SLABS];
  logic [LINK_W-1:0] hd_r   [3];
  logic [CNT_W-1:0]  cnt_r  [3];

  logic [SLAB_W-1:0] si_r;
  logic [OBJ_W-1:0]  oi_r;
  logic [SLAB_W-1:0] s_r;
  logic [LINK_W-1:0] i_r;
  logic [FC_W-1:0]   o_r;
  logic [FC_W-1:0]   fcv_r;
  logic [1:0]        tgt_r;
  logic [1:0]        status_r;
  logic [SLAB_W-1:0] gslab_r;
  logic [OBJ_W-1:0]  gobj_r;
  logic [CNT_W-1:0]  rel_r;

  logic [FC_W-1:0]   cap;
  logic [4:0]        lim;
  logic [FC_W-1:0]   fc_dec;
  logic [FC_W-1:0]   fc_inc;
  logic [1:0]        c_s;
  logic [1:0]        hx;
  logic [LINK_W-1:0] n_s;
  logic [LINK_W-1:0] p_s;
  logic [LINK_W-1:0] h_t;
  logic [SLAB_W-1:0] e_s;

  // clamp configuration values and look up the current slab's entries
  always_comb begin
    if (objs_r == 7'd0) begin
      cap = FC_W'(1);
    end else if (objs_r > 7'(MAX_OBJECTS)) begin
      cap = FC_W'(MAX_OBJECTS);
    end else begin
      cap = FC_W'(objs_r);
    end
    lim    = (limit_r > 5'(NUM_SLABS)) ? 5'(NUM_SLABS) : limit_r;
    fc_dec = fc_r[s_r] - FC_W'(1);
    fc_inc = fc_r[s_r] + FC_W'(1);
    c_s    = cls_r[s_r];
    hx     = c_s - 2'd1;
    n_s    = nx_r[s_r];
    p_s    = pv_r[s_r];
    h_t    = hd_r[tgt_r - 2'd1];
    e_s    = hd_r[0][SLAB_W-1:0];
  end

  // memory addressing per step
  always_comb begin
    mreq = '0;
    unique case (state_r)
      S_CARVE: begin
        mreq.st_we    = 1'b1;
        mreq.st_addr  = {s_r, o_r[OBJ_W-1:0]};
        mreq.st_wdata = o_r[OBJ_W-1:0];
        mreq.iu_we    = 1'b1;
        mreq.iu_addr  = {s_r, o_r[OBJ_W-1:0]};
      end
      S_POP: begin
        mreq.st_addr = {s_r, fc_dec[OBJ_W-1:0]};
      end
      S_ARD: begin
        mreq.iu_we    = 1'b1;
        mreq.iu_addr  = {s_r, st_rdata};
        mreq.iu_wdata = 1'b1;
      end
      S_FCHK: begin
        mreq.iu_addr = {si_r, oi_r};
      end
      S_FRD: begin
        mreq.st_we    = iu_rdata;
        mreq.st_addr  = {s_r, fc_r[s_r][OBJ_W-1:0]};
        mreq.st_wdata = oi_r;
        mreq.iu_we    = iu_rdata;
        mreq.iu_addr  = {s_r, oi_r};
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = '{status: status_r, slab: gslab_r, obj: gobj_r, released: rel_r,
                  n_empty: cnt_r[0], n_partial: cnt_r[1], n_full: cnt_r[2]};

  // sequencer, slab table and lists
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      objs_r  <= 7'(MAX_OBJECTS);
      limit_r <= 5'(NUM_SLABS);
      for (int k = 0; k < NUM_SLABS; k++) begin
        cls_r[k] <= CLS_UNUSED;
        fc_r[k]  <= '0;
        cap_r[k] <= '0;
        nx_r[k]  <= NIL;
        pv_r[k]  <= NIL;
      end
      for (int k = 0; k < 3; k++) begin
        hd_r[k]  <= NIL;
        cnt_r[k] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_valid) begin
        if (cfg_index == REG_OBJS) begin
          objs_r <= cfg_data;
        end else begin
          limit_r <= cfg_data[4:0];
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            si_r     <= in_slab_index;
            oi_r     <= in_object_index;
            status_r <= ST_OK;
            gslab_r  <= '0;
            gobj_r   <= '0;
            rel_r    <= '0;
            unique case (in_func)
              FN_ALLOC:  state_r <= S_ASEL;
              FN_FREE:   state_r <= S_FCHK;
              FN_SHRINK: state_r <= S_SHRINK;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        // pick a partial, then an empty slab, else search
        S_ASEL: begin
          if (hd_r[1] != NIL) begin
            s_r     <= hd_r[1][SLAB_W-1:0];
            state_r <= S_POP;
          end else if (hd_r[0] != NIL) begin
            s_r     <= hd_r[0][SLAB_W-1:0];
            state_r <= S_POP;
          end else begin
            i_r     <= '0;
            state_r <= S_SEARCH;
          end
        end
        // scan for the lowest unused slab, one per cycle
        S_SEARCH: begin
          if (i_r >= LINK_W'(lim)) begin
            status_r <= ST_NOMEM;
            state_r  <= S_DONE;
          end else if (cls_r[i_r[SLAB_W-1:0]] == CLS_UNUSED) begin
            s_r     <= i_r[SLAB_W-1:0];
            o_r     <= '0;
            state_r <= S_CARVE;
          end else begin
            i_r <= i_r + LINK_W'(1);
          end
        end
        // carve one object per cycle, then push onto the empty list
        S_CARVE: begin
          if (o_r == cap - FC_W'(1)) begin
            cap_r[s_r] <= cap;
            fc_r[s_r]  <= cap;
            pv_r[s_r]  <= NIL;
            nx_r[s_r]  <= hd_r[0];
            if (hd_r[0] != NIL) begin
              pv_r[e_s] <= LINK_W'(s_r);
            end
            hd_r[0]    <= LINK_W'(s_r);
            cnt_r[0]   <= cnt_r[0] + CNT_W'(1);
            cls_r[s_r] <= CLS_EMPTY;
            state_r    <= S_POP;
          end else begin
            o_r <= o_r + FC_W'(1);
          end
        end
        S_POP: begin
          fc_r[s_r] <= fc_dec;
          fcv_r     <= fc_dec;
          state_r   <= S_ARD;
        end
        S_ARD: begin
          gobj_r  <= st_rdata;
          gslab_r <= s_r;
          if (fcv_r == '0) begin
            tgt_r   <= CLS_FULL;
            state_r <= S_UNLINK;
          end else if (c_s == CLS_EMPTY) begin
            tgt_r   <= CLS_PARTIAL;
            state_r <= S_UNLINK;
          end else begin
            state_r <= S_DONE;
          end
        end
        // check the freed object against the slab
        S_FCHK: begin
          s_r <= si_r;
          if (cls_r[si_r] == CLS_UNUSED || FC_W'(oi_r) >= cap_r[si_r] ||
              fc_r[si_r] >= cap_r[si_r]) begin
            status_r <= ST_BADFREE;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_FRD;
          end
        end
        S_FRD: begin
          if (!iu_rdata) begin
            status_r <= ST_BADFREE;
            state_r  <= S_DONE;
          end else begin
            fc_r[s_r] <= fc_inc;
            if (fc_inc == cap_r[s_r]) begin
              tgt_r   <= CLS_EMPTY;
              state_r <= S_UNLINK;
            end else if (c_s == CLS_FULL) begin
              tgt_r   <= CLS_PARTIAL;
              state_r <= S_UNLINK;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        // take the slab off its list
        S_UNLINK: begin
          if (p_s != NIL) begin
            nx_r[p_s[SLAB_W-1:0]] <= n_s;
          end else begin
            hd_r[hx] <= n_s;
          end
          if (n_s != NIL) begin
            pv_r[n_s[SLAB_W-1:0]] <= p_s;
          end
          cnt_r[hx]  <= cnt_r[hx] - CNT_W'(1);
          cls_r[s_r] <= CLS_UNUSED;
          state_r    <= S_PUSH;
        end
        // put it at the head of the target list
        S_PUSH: begin
          pv_r[s_r] <= NIL;
          nx_r[s_r] <= h_t;
          if (h_t != NIL) begin
            pv_r[h_t[SLAB_W-1:0]] <= LINK_W'(s_r);
          end
          hd_r[tgt_r - 2'd1]  <= LINK_W'(s_r);
          cnt_r[tgt_r - 2'd1] <= cnt_r[tgt_r - 2'd1] + CNT_W'(1);
          cls_r[s_r]          <= tgt_r;
          state_r             <= S_DONE;
        end
        // release the head empty slab, one per cycle
        S_SHRINK: begin
          if (hd_r[0] == NIL) begin
            state_r <= S_DONE;
          end else begin
            hd_r[0] <= nx_r[e_s];
            if (nx_r[e_s] != NIL) begin
              pv_r[nx_r[e_s][SLAB_W-1:0]] <= NIL;
            end
            nx_r[e_s]  <= NIL;
            pv_r[e_s]  <= NIL;
            cnt_r[0]   <= cnt_r[0] - CNT_W'(1);
            cls_r[e_s] <= CLS_UNUSED;
            fc_r[e_s]  <= '0;
            cap_r[e_s] <= '0;
            rel_r      <= rel_r + CNT_W'(1);
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/slab_object_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slab_object_allocator
// Fixed pool of slabs with per-slab object stacks and per-class slab lists.
// ----------------------------------------------------------------------------
// channel   handshake            payload
// in        start / busy         in_func, in_slab_index, in_object_index
// out       out_valid (strobe)   out_status .. out_full_slabs
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Allocate from a listed slab pops an object and moves the slab to another
// list if its class changes; a fresh slab is found by a scan and carved
// (up to 64 objects), with separate search and carve counters. Free checks
// the object and its in-use flag; shrink releases every empty slab. The
// result is registered. Synchronous active-low reset; no stall on output.
// ----------------------------------------------------------------------------
module slab_object_allocator
  import soa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_func,
  input  wire logic [SLAB_W-1:0] in_slab_index,
  input  wire logic [OBJ_W-1:0]  in_object_index,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [6:0]        cfg_data,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [SLAB_W-1:0]      out_given_slab,
  output logic [OBJ_W-1:0]       out_given_object,
  output logic [CNT_W-1:0]       out_released_slabs,
  output logic [CNT_W-1:0]       out_empty_slabs,
  output logic [CNT_W-1:0]       out_partial_slabs,
  output logic [CNT_W-1:0]       out_full_slabs
);

  logic             ctl_busy;
  logic             ctl_done;
  result_t          ctl_res;
  mem_req_t         mreq;
  logic [OBJ_W-1:0] st_rdata;
  logic             iu_rdata;
  logic             out_valid_r;
  result_t          res_r;

  soa_slab_ctl u_ctl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_func         (in_func),
    .in_slab_index   (in_slab_index),
    .in_object_index (in_object_index),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .busy            (ctl_busy),
    .done            (ctl_done),
    .res             (ctl_res),
    .mreq            (mreq),
    .st_rdata        (st_rdata),
    .iu_rdata        (iu_rdata)
  );

  soa_obj_mem u_mem (
    .clk      (clk),
    .req      (mreq),
    .st_rdata (st_rdata),
    .iu_rdata (iu_rdata)
  );

  // register the result for its one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_done;
    end
    if (ctl_done) begin
      res_r <= ctl_res;
    end
  end

  assign busy               = ctl_busy;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_given_slab     = res_r.slab;
  assign out_given_object   = res_r.obj;
  assign out_released_slabs = res_r.released;
  assign out_empty_slabs    = res_r.n_empty;
  assign out_partial_slabs  = res_r.n_partial;
  assign out_full_slabs     = res_r.n_full;

endmodule
`default_nettype wire

// ===== rtl/core/soa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soa_checker
// Port-level checks on request and result timing and result consistency.
// ----------------------------------------------------------------------------
module soa_checker
  import soa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [1:0]        out_status,
  input wire logic [SLAB_W-1:0] out_given_slab,
  input wire logic [OBJ_W-1:0]  out_given_object,
  input wire logic [CNT_W-1:0]  out_empty_slabs,
  input wire logic [CNT_W-1:0]  out_partial_slabs,
  input wire logic [CNT_W-1:0]  out_full_slabs
);

  // an accepted request keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // a result only closes a busy period
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result without a finished request");

  // status is a defined code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOMEM ||
                   out_status == ST_BADFREE))
    else $error("undefined status");

  // failed allocate hands out nothing
  a_nomem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOMEM |->
      out_given_slab == '0 && out_given_object == '0)
    else $error("object given on out of memory");

  // slab counts never exceed the pool
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (7'(out_empty_slabs) + 7'(out_partial_slabs) +
                   7'(out_full_slabs)) <= 7'(NUM_SLABS))
    else $error("slab counts exceed pool");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_given_slab    (out_given_slab),
  .out_given_object  (out_given_object),
  .out_empty_slabs   (out_empty_slabs),
  .out_partial_slabs (out_partial_slabs),
  .out_full_slabs    (out_full_slabs)
);
`default_nettype wire
